// ===== sv/fpat_pkg.sv =====
// ----------------------------------------------------------------------------
// fpat_pkg
// Shared widths, status codes and control structs of the FIFO paged address
// translator.
// ----------------------------------------------------------------------------
package fpat_pkg;

  localparam int PAGE_W   = 7;
  localparam int OFFS_W   = 7;
  localparam int FRAME_W  = 8;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 15;

  localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

  // Commands into the resident ring.
  typedef struct packed {
    logic push;    // append page, grow count
    logic rotate;  // append page, drop oldest (count stays)
  } ring_cmd_t;

  // Status out of the resident ring.
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ===== sv/fpat_ram.sv =====
// ----------------------------------------------------------------------------
// fpat_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fpat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/fpat_ring.sv =====
// ----------------------------------------------------------------------------
// fpat_ring
// FIFO ring of resident pages: head and count registers around a ring RAM.
// The read port is addressed by the head, so it shows the oldest page, registered.
// ----------------------------------------------------------------------------
module fpat_ring #(
  parameter int RING_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpat_pkg::ring_cmd_t       cmd,
  input  logic [fpat_pkg::PAGE_W-1:0] wr_page,
  output logic [fpat_pkg::PAGE_W-1:0] oldest_page,
  output fpat_pkg::ring_stat_t      stat
);
  import fpat_pkg::*;

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;

  logic [RING_AW-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   tail_sum;
  logic [RING_AW-1:0] tail;

  // Tail slot: head plus count, wrapped once.
  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(RING_DEPTH)) begin
      tail = RING_AW'(tail_sum - SUM_W'(RING_DEPTH));
    end else begin
      tail = RING_AW'(tail_sum);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.rotate) begin
      if (head_r == RING_AW'(RING_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + RING_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  fpat_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (cmd.push | cmd.rotate),
    .wr_addr (tail),
    .wr_data (wr_page),
    .rd_addr (head_r),
    .rd_data (oldest_page)
  );

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(RING_DEPTH));

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RING_DEPTH))
    else $error("ring count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full)
    else $error("push into full ring");

  a_no_rotate_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |=> !stat.empty && $stable(count_r))
    else $error("rotate changed count or ran on empty ring");
`endif

endmodule

// ===== sv/fifo_paged_address_translator.sv =====
// ----------------------------------------------------------------------------
// fifo_paged_address_translator
// Paged address translation with FIFO page replacement, built around a page
// table RAM (present bit + frame) and a ring RAM of resident pages.
// ----------------------------------------------------------------------------
// Sequence: a hit, a load or an error is decided in S_EXEC, and its result
//   is registered from there onto out_valid; a fault goes on through S_VRD
//   and S_FWR (extra page table read of the victim and a second write) first.
// Items: no new item is taken before the last one is done; this is set by the
//   read-modify-write of the page table RAM, read on accept and written back
//   in the next cycle with busy high until the write is done.
// Reset: synchronous, active low; then a clearing pass over every entry
//   zeroes the page table with busy high. Results are strobed for one cycle.
module fifo_paged_address_translator #(
  parameter int PAGES          = 128,
  parameter int UNITS_PER_PAGE = 128,
  parameter int FRAMES         = 256,
  parameter int RING_DEPTH     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [fpat_pkg::PAGE_W-1:0]   in_page,
  input  logic [fpat_pkg::OFFS_W-1:0]   in_offset,
  input  logic                          in_resident,
  input  logic [fpat_pkg::FRAME_W-1:0]  in_frame,
  output logic                          out_valid,
  output logic [fpat_pkg::STATUS_W-1:0] out_status,
  output logic [fpat_pkg::ADDR_W-1:0]   out_address,
  output logic [fpat_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic                          out_evicted_valid
);
  import fpat_pkg::*;

  localparam int PG_AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PTE_W = FRAME_W + 1;  // {present, frame}

  // Sequencer: clear sweep, idle, decide, victim read, fault write-back.
  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_EXEC = 5'b00100,
    S_VRD  = 5'b01000,
    S_FWR  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [PG_AW-1:0] clr_idx_r, clr_idx_nxt;

  // Latched item.
  logic               op_r;
  logic [PAGE_W-1:0]  page_r;
  logic [OFFS_W-1:0]  offset_r;
  logic               res_r;
  logic [FRAME_W-1:0] frame_r;
  logic [PAGE_W-1:0]  victim_r, victim_nxt;
  logic [FRAME_W-1:0] vframe_r, vframe_nxt;

  logic accept;

  // Page table RAM ports.
  logic             pt_we;
  logic [PG_AW-1:0] pt_waddr;
  logic [PTE_W-1:0] pt_wdata;
  logic [PG_AW-1:0] pt_raddr;
  logic [PTE_W-1:0] pt_rdata;
  logic             pt_present;
  logic [FRAME_W-1:0] pt_frame;

  // Ring.
  ring_cmd_t         ring_cmd;
  ring_stat_t        ring_stat;
  logic [PAGE_W-1:0] oldest_page;

  // Decode of the latched item.
  logic page_ok, frame_ok;

  // Address path.
  logic [FRAME_W-1:0] addr_frame;
  logic [31:0]        addr_full;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   address_r, address_nxt;
  logic [PAGE_W-1:0]   evpage_r, evpage_nxt;
  logic                evvalid_r, evvalid_nxt;

  assign busy   = (state_r != S_IDLE);
  assign accept = start & ~busy;

  assign pt_present = pt_rdata[PTE_W-1];
  assign pt_frame   = pt_rdata[FRAME_W-1:0];

  assign page_ok  = (32'(page_r) < 32'(PAGES));
  assign frame_ok = (32'(frame_r) < 32'(FRAMES));

  // Read the requested entry on accept; read the victim entry while deciding.
  assign pt_raddr = (state_r == S_EXEC) ? PG_AW'(oldest_page) : PG_AW'(in_page);

  // Frame times page size plus offset, kept to the port width.
  assign addr_frame = (state_r == S_FWR) ? vframe_r : pt_frame;
  assign addr_full  = 32'(addr_frame) * 32'(UNITS_PER_PAGE) + 32'(offset_r);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    victim_nxt    = victim_r;
    vframe_nxt    = vframe_r;
    pt_we         = 1'b0;
    pt_waddr      = PG_AW'(page_r);
    pt_wdata      = '0;
    ring_cmd      = '0;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    address_nxt   = address_r;
    evpage_nxt    = evpage_r;
    evvalid_nxt   = evvalid_r;

    unique case (state_r)
      S_CLR: begin
        // Sweep the page table, one entry a cycle.
        pt_we    = 1'b1;
        pt_waddr = clr_idx_r;
        pt_wdata = '0;
        if (clr_idx_r == PG_AW'(PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + PG_AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_ERROR;
        address_nxt   = '0;
        evpage_nxt    = '0;
        evvalid_nxt   = 1'b0;
        if (!page_ok) begin
          status_nxt = ST_ERROR;
        end else if (op_r == OP_LOAD) begin
          if (pt_present) begin
            status_nxt = ST_ERROR;         // reload of a resident page
          end else if (!res_r) begin
            status_nxt = ST_LOADED;        // absent page, nothing to record
          end else if (!frame_ok || ring_stat.full) begin
            status_nxt = ST_ERROR;
          end else begin
            pt_we         = 1'b1;
            pt_wdata      = {1'b1, frame_r};
            ring_cmd.push = 1'b1;
            status_nxt    = ST_LOADED;
          end
        end else if (pt_present) begin
          status_nxt  = ST_HIT;
          address_nxt = addr_full[ADDR_W-1:0];
        end else if (ring_stat.empty) begin
          status_nxt = ST_ERROR;           // fault with nothing to evict
        end else begin
          // Fault: rotate the ring now, fetch the victim's frame next.
          ring_cmd.rotate = 1'b1;
          victim_nxt      = oldest_page;
          out_valid_nxt   = 1'b0;
          state_nxt       = S_VRD;
        end
      end

      S_VRD: begin
        // Drop the victim's present bit, hold its frame.
        pt_we      = 1'b1;
        pt_waddr   = PG_AW'(victim_r);
        pt_wdata   = {1'b0, pt_frame};
        vframe_nxt = pt_frame;
        state_nxt  = S_FWR;
      end

      S_FWR: begin
        // Hand the frame to the requested page and report the eviction.
        pt_we         = 1'b1;
        pt_waddr      = PG_AW'(page_r);
        pt_wdata      = {1'b1, vframe_r};
        out_valid_nxt = 1'b1;
        status_nxt    = ST_FAULT;
        address_nxt   = addr_full[ADDR_W-1:0];
        evpage_nxt    = victim_r;
        evvalid_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      page_r   <= in_page;
      offset_r <= in_offset;
      res_r    <= in_resident;
      frame_r  <= in_frame;
    end
    victim_r  <= victim_nxt;
    vframe_r  <= vframe_nxt;
    status_r  <= status_nxt;
    address_r <= address_nxt;
    evpage_r  <= evpage_nxt;
    evvalid_r <= evvalid_nxt;
  end

  fpat_ram #(
    .WIDTH (PTE_W),
    .DEPTH (PAGES)
  ) u_pt_ram (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_waddr),
    .wr_data (pt_wdata),
    .rd_addr (pt_raddr),
    .rd_data (pt_rdata)
  );

  fpat_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ring_cmd),
    .wr_page     (page_r),
    .oldest_page (oldest_page),
    .stat        (ring_stat)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_address       = address_r;
  assign out_evicted_page  = evpage_r;
  assign out_evicted_valid = evvalid_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted item did not hold busy");

  a_fault_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWR) |-> $past(state_r == S_VRD) && $past(state_r == S_EXEC, 2))
    else $error("fault write-back out of sequence");

  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_evicted_valid == (out_status == ST_FAULT)))
    else $error("eviction flag does not match status");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results closer than two cycles");
`endif

endmodule

// ===== tb/sv/fpat_translation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpat_translation_checker
// Watches the item and result channels of the paged address translator. It
// keeps its own page table and resident ring and predicts each result. It
// compares every strobed result with the oldest prediction and counts
// mismatches.
// ----------------------------------------------------------------------------
module fpat_translation_checker #(
  parameter int PAGES          = 128,
  parameter int UNITS_PER_PAGE = 128,
  parameter int FRAMES         = 256,
  parameter int RING_DEPTH     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_operation,
  input  logic [fpat_pkg::PAGE_W-1:0]   in_page,
  input  logic [fpat_pkg::OFFS_W-1:0]   in_offset,
  input  logic                          in_resident,
  input  logic [fpat_pkg::FRAME_W-1:0]  in_frame,
  input  logic                          out_valid,
  input  logic [fpat_pkg::STATUS_W-1:0] out_status,
  input  logic [fpat_pkg::ADDR_W-1:0]   out_address,
  input  logic [fpat_pkg::PAGE_W-1:0]   out_evicted_page,
  input  logic                          out_evicted_valid,
  output int unsigned                   mismatch_count,
  output int unsigned                   outstanding
);

  import fpat_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
    logic [PAGE_W-1:0]   evicted_page;
    logic                evicted_valid;
  } translation_t;

  // Shadow page table and resident ring.
  logic               page_present [PAGES];
  logic [FRAME_W-1:0] frame_of     [PAGES];
  logic [PAGE_W-1:0]  ring_pages   [RING_DEPTH];
  int                 ring_head;
  int                 ring_count;

  translation_t expected_results [$];
  translation_t want;

  // Work out the result of one item and update the shadow state.
  function automatic translation_t translate_item(logic op, logic [PAGE_W-1:0] pg,
                                                  logic [OFFS_W-1:0] offs, logic res,
                                                  logic [FRAME_W-1:0] frm);
    translation_t r;
    int victim;
    r.status        = ST_ERROR;
    r.address       = '0;
    r.evicted_page  = '0;
    r.evicted_valid = 1'b0;
    if (pg >= PAGES) return r;
    if (op == OP_LOAD) begin
      if (page_present[pg]) return r;
      if (!res) begin
        r.status = ST_LOADED;
        return r;
      end
      if (frm >= FRAMES || ring_count >= RING_DEPTH) return r;
      page_present[pg] = 1'b1;
      frame_of[pg]     = frm;
      ring_pages[(ring_head + ring_count) % RING_DEPTH] = pg;
      ring_count++;
      r.status = ST_LOADED;
      return r;
    end
    if (page_present[pg]) begin
      r.status  = ST_HIT;
      r.address = ADDR_W'(int'(frame_of[pg]) * UNITS_PER_PAGE + int'(offs));
      return r;
    end
    if (ring_count == 0) return r;
    // Hand the oldest page's frame over, rotate the ring.
    victim               = ring_pages[ring_head];
    frame_of[pg]         = frame_of[victim];
    page_present[victim] = 1'b0;
    page_present[pg]     = 1'b1;
    ring_pages[(ring_head + ring_count) % RING_DEPTH] = pg;
    ring_head = (ring_head + 1) % RING_DEPTH;
    r.status        = ST_FAULT;
    r.address       = ADDR_W'(int'(frame_of[pg]) * UNITS_PER_PAGE + int'(offs));
    r.evicted_page  = PAGE_W'(victim);
    r.evicted_valid = 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAGES; p++) page_present[p] = 1'b0;
      ring_head      = 0;
      ring_count     = 0;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d address %0d",
                   $time, out_status, out_address);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("address", want.address, out_address);
          check_field("evicted_page", want.evicted_page, out_evicted_page);
          check_field("evicted_valid", want.evicted_valid, out_evicted_valid);
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_results.push_back(translate_item(in_operation, in_page, in_offset,
                                                  in_resident, in_frame));
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives load and access items into the FIFO paged address translator: a
// directed opening over the edge cases, then random bursts that keep most
// pages inside a small pool so hits, faults and full-ring errors recur.
// The checker beside the block predicts and compares; this module only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  import fpat_pkg::*;

  localparam int PAGES          = 128;
  localparam int UNITS_PER_PAGE = 128;
  localparam int FRAMES         = 256;
  localparam int RING_DEPTH     = 16;
  localparam int RANDOM_ITEMS   = 400;
  // Covers the clearing pass after reset, the longest sender gap and a fault.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_operation;
  logic [PAGE_W-1:0]   in_page;
  logic [OFFS_W-1:0]   in_offset;
  logic                in_resident;
  logic [FRAME_W-1:0]  in_frame;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_address;
  logic [PAGE_W-1:0]   out_evicted_page;
  logic                out_evicted_valid;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned idle_cycles;

  fifo_paged_address_translator #(
    .PAGES          (PAGES),
    .UNITS_PER_PAGE (UNITS_PER_PAGE),
    .FRAMES         (FRAMES),
    .RING_DEPTH     (RING_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_page           (in_page),
    .in_offset         (in_offset),
    .in_resident       (in_resident),
    .in_frame          (in_frame),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_address       (out_address),
    .out_evicted_page  (out_evicted_page),
    .out_evicted_valid (out_evicted_valid)
  );

  fpat_translation_checker #(
    .PAGES          (PAGES),
    .UNITS_PER_PAGE (UNITS_PER_PAGE),
    .FRAMES         (FRAMES),
    .RING_DEPTH     (RING_DEPTH)
  ) checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_page           (in_page),
    .in_offset         (in_offset),
    .in_resident       (in_resident),
    .in_frame          (in_frame),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_address       (out_address),
    .out_evicted_page  (out_evicted_page),
    .out_evicted_valid (out_evicted_valid),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Count cycles in which no item is taken and no result comes out; a
  // stuck block ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one item at the current falling edge and hold it until the
  // block takes it. Busy only moves on rising edges, so sampling it at the
  // falling edge tells whether the next rising edge accepts. Return at the
  // falling edge after acceptance, with start still high.
  task automatic issue_item(input logic op, input logic [PAGE_W-1:0] pg,
                            input logic [OFFS_W-1:0] offs, input logic res,
                            input logic [FRAME_W-1:0] frm);
    start        <= 1'b1;
    in_operation <= op;
    in_page      <= pg;
    in_offset    <= offs;
    in_resident  <= res;
    in_frame     <= frm;
    while (busy !== 1'b0) @(negedge clk);
    @(negedge clk);
  endtask

  int sent;
  int burst_len;
  int gap;
  int kind;
  logic [PAGE_W-1:0] pick;

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_LOAD;
    in_page      = '0;
    in_offset    = '0;
    in_resident  = 1'b0;
    in_frame     = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening.
    // Fault with nothing resident: error.
    issue_item(OP_ACCESS, 7'd5, 7'd3, 1'b0, 8'd0);
    // Load of a page that is not in memory: loaded, page stays absent.
    issue_item(OP_LOAD, 7'd0, 7'd0, 1'b0, 8'd17);
    issue_item(OP_ACCESS, 7'd0, 7'd1, 1'b0, 8'd0);
    // Extreme frames at the extreme pages.
    issue_item(OP_LOAD, 7'd0, 7'd0, 1'b1, 8'd255);
    issue_item(OP_LOAD, 7'd127, 7'd127, 1'b1, 8'd0);
    // Reload of a present page, either resident flag: error.
    issue_item(OP_LOAD, 7'd0, 7'd0, 1'b1, 8'd9);
    issue_item(OP_LOAD, 7'd0, 7'd0, 1'b0, 8'd9);
    // Hits at the top and bottom of the address range.
    issue_item(OP_ACCESS, 7'd0, 7'd127, 1'b0, 8'd0);
    issue_item(OP_ACCESS, 7'd127, 7'd0, 1'b1, 8'd255);
    // Fill the ring, then overflow it.
    for (int p = 1; p <= RING_DEPTH - 2; p++)
      issue_item(OP_LOAD, PAGE_W'(p), PAGE_W'($urandom_range(0, 127)), 1'b1,
                 FRAME_W'($urandom_range(0, 255)));
    issue_item(OP_LOAD, 7'd50, 7'd0, 1'b1, 8'd77);
    // Fault on a full ring: oldest page gives up its frame.
    issue_item(OP_ACCESS, 7'd60, 7'd64, 1'b0, 8'd0);

    // Random bursts: mostly accesses and loads on a small page pool so the
    // ring churns, plus some items with every field random.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 12);
      for (int i = 0; i < burst_len; i++) begin
        kind = $urandom_range(0, 99);
        pick = ($urandom_range(0, 99) < 85) ? PAGE_W'($urandom_range(0, 23))
                                            : PAGE_W'($urandom_range(0, 127));
        if (kind < 60)
          issue_item(OP_ACCESS, pick, OFFS_W'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)), FRAME_W'($urandom_range(0, 255)));
        else if (kind < 85)
          issue_item(OP_LOAD, pick, OFFS_W'($urandom_range(0, 127)),
                     ($urandom_range(0, 3) != 0), FRAME_W'($urandom_range(0, 255)));
        else
          issue_item(1'($urandom), PAGE_W'($urandom), OFFS_W'($urandom),
                     1'($urandom), FRAME_W'($urandom));
        sent++;
      end
      // Drop start only when a real gap follows, so it never toggles
      // twice at one edge.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    start <= 1'b0;

    // Drain: wait for every predicted result, then let the pipe settle.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== fifo_paged_address_translator.f =====
sv/fpat_pkg.sv
sv/fpat_ram.sv
sv/fpat_ring.sv
sv/fifo_paged_address_translator.sv
tb/sv/fpat_translation_checker.sv
tb/sv/tb.sv
